### sv/gnt_pkg.sv
// Shared constants, codes and types for the gradient noise turbulence block.
`default_nettype none
package gnt_pkg;

  localparam int TABLE_SIZE       = 256;
  localparam int IDX_W            = $clog2(TABLE_SIZE);
  localparam int DEF_FRAC_BITS    = 16;
  localparam int DEF_MAX_OCTAVES  = 8;
  localparam int GRAD_W           = 16;
  localparam int GRAD_FRAC        = 14;
  localparam int OUT_FRAC         = 16;
  localparam int OUT_W            = 18;
  localparam logic [OUT_W-1:0] OUT_MAX = 18'h3FFFF;

  // Operation codes
  localparam logic [2:0] OP_WR_PX = 3'd0;
  localparam logic [2:0] OP_WR_PY = 3'd1;
  localparam logic [2:0] OP_WR_PZ = 3'd2;
  localparam logic [2:0] OP_WR_GR = 3'd3;
  localparam logic [2:0] OP_EVAL  = 3'd4;

  // Tag that travels with one corner through the pipeline
  typedef struct packed {
    logic       vld;
    logic [2:0] corner;  // {di, dj, dk}
  } gnt_tag_t;

endpackage
`default_nettype wire

### sv/gnt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module gnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### sv/gnt_corner.sv
// Corner pipeline: gradient dot offset, then three smoothstep weight multiplies.
`default_nettype none
module gnt_corner
  import gnt_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gnt_tag_t                      tag_i,
  input  wire logic [3*GRAD_W-1:0]           grad_i,
  input  wire logic [FRAC_BITS-1:0]          frac_x_i,
  input  wire logic [FRAC_BITS-1:0]          frac_y_i,
  input  wire logic [FRAC_BITS-1:0]          frac_z_i,
  input  wire logic [FRAC_BITS:0]            sw_x_i,
  input  wire logic [FRAC_BITS:0]            sw_y_i,
  input  wire logic [FRAC_BITS:0]            sw_z_i,
  output logic                               busy_o,
  output logic                               term_vld_o,
  output logic signed [FRAC_BITS+4:0]        term_o
);

  localparam int F   = FRAC_BITS;
  localparam int OW  = F + 2;
  localparam int PW  = GRAD_W + OW;
  localparam int SW  = PW + 2;
  localparam int DW  = F + 5;
  localparam int MW  = DW + OW;
  localparam logic [F:0] ONE_U = {1'b1, {F{1'b0}}};

  gnt_tag_t tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic signed [DW-1:0] d3_q, d4_q, d5_q, d6_q;

  logic signed [OW-1:0] ox, oy, oz;
  logic signed [GRAD_W-1:0] gx, gy, gz;
  logic signed [SW-1:0] dsum, dshr;
  logic [F:0] w4, w5, w6;
  logic signed [MW-1:0] m4, m5, m6;

  always_comb begin
    gx = signed'(grad_i[GRAD_W-1:0]);
    gy = signed'(grad_i[2*GRAD_W-1:GRAD_W]);
    gz = signed'(grad_i[3*GRAD_W-1:2*GRAD_W]);
    ox = signed'({2'b00, frac_x_i});
    oy = signed'({2'b00, frac_y_i});
    oz = signed'({2'b00, frac_z_i});
    if (tag_i.corner[2]) ox = ox - signed'({1'b0, ONE_U});
    if (tag_i.corner[1]) oy = oy - signed'({1'b0, ONE_U});
    if (tag_i.corner[0]) oz = oz - signed'({1'b0, ONE_U});
    dsum = {{2{px_q[PW-1]}}, px_q} + {{2{py_q[PW-1]}}, py_q} + {{2{pz_q[PW-1]}}, pz_q};
    dshr = dsum >>> GRAD_FRAC;
    w4 = tag3_q.corner[2] ? sw_x_i : ONE_U - sw_x_i;
    w5 = tag4_q.corner[1] ? sw_y_i : ONE_U - sw_y_i;
    w6 = tag5_q.corner[0] ? sw_z_i : ONE_U - sw_z_i;
    m4 = MW'(d3_q) * MW'(signed'({1'b0, w4}));
    m5 = MW'(d4_q) * MW'(signed'({1'b0, w5}));
    m6 = MW'(d5_q) * MW'(signed'({1'b0, w6}));
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    px_q <= PW'(gx) * PW'(ox);
    py_q <= PW'(gy) * PW'(oy);
    pz_q <= PW'(gz) * PW'(oz);
    d3_q <= dshr[DW-1:0];
    d4_q <= DW'(m4 >>> F);
    d5_q <= DW'(m5 >>> F);
    d6_q <= DW'(m6 >>> F);
  end

  // Advance tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      tag5_q <= '0;
      tag6_q <= '0;
    end else begin
      tag2_q <= tag_i;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      tag5_q <= tag4_q;
      tag6_q <= tag5_q;
    end
  end

  assign busy_o     = tag2_q.vld | tag3_q.vld | tag4_q.vld | tag5_q.vld | tag6_q.vld;
  assign term_vld_o = tag6_q.vld;
  assign term_o     = d6_q;

endmodule
`default_nettype wire

### sv/gradient_noise_turbulence.sv
// Top level: 3-D gradient noise turbulence with table memories and octave sequencer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | operation, entry_index, perm_value,
//          |           |                         | grad_x/y/z, point_x/y/z, octaves
//  out     | source    | out_valid_o/out_stall_i | turbulence
//
//  A load transfer writes one memory entry.
//  An evaluate runs per octave a phase of permutation reads (one memory port, six
//  reads), issues the eight corners to the gradient memory, drains the corner
//  pipeline and folds the octave in. A final state loads the result, and the input
//  stalls until it is loaded.
//  Reset clears control state only; the tables are undefined until written.
//  The next transfer is taken while a finished result waits on a stalled output.
`default_nettype none
module gradient_noise_turbulence
  import gnt_pkg::*;
#(
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         operation_i,
  input  wire logic [7:0]         entry_index_i,
  input  wire logic [7:0]         perm_value_i,
  input  wire logic signed [15:0] grad_x_i,
  input  wire logic signed [15:0] grad_y_i,
  input  wire logic signed [15:0] grad_z_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  input  wire logic [3:0]         octaves_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [OUT_W-1:0]        turbulence_o
);

  localparam int F     = FRAC_BITS;
  localparam int DW    = F + 5;
  localparam int NW    = DW + 3;
  localparam int SUMW  = NW + 2;
  localparam int MAGW  = SUMW + OUT_FRAC;
  localparam int OCW   = $clog2(MAX_OCTAVES + 1);
  localparam int PAW   = $clog2(3 * TABLE_SIZE);
  localparam int SHL   = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
  localparam int SHR   = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam logic [F+1:0] THREE_ONE = {2'b11, {F{1'b0}}};
  localparam logic [4:0]   MAXO5     = 5'(MAX_OCTAVES);

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PERM   = 3'd1;
  localparam logic [2:0] S_CORNER = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_ACC    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]  state_q;
  logic [2:0]  cnt_q;
  logic        rdv_q;
  logic [2:0]  rdk_q;
  logic [31:0] pt_q [3];
  logic [OCW-1:0] oct_n_q, oct_tot_q;
  logic [IDX_W-1:0] perm_q [6];
  logic [F-1:0] t_q [3];
  logic [F:0]   s_q [3];
  logic signed [NW-1:0]   noise_q;
  logic signed [SUMW-1:0] sum_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  turb_q;
  gnt_tag_t          tag1_q;

  logic in_acc, out_free;
  logic perm_we, grad_we;
  logic [PAW-1:0] perm_waddr, perm_raddr;
  logic [IDX_W-1:0] perm_rdata, cell_sel, hash;
  logic [3*GRAD_W-1:0] grad_rdata;
  logic [F-1:0] frac [3];
  logic pipe_busy, term_vld;
  logic signed [DW-1:0] term;
  logic [4:0] oct_sat;
  logic signed [NW-1:0] noise_sh;
  logic [SUMW-1:0] mag;
  logic [MAGW-1:0] wide;
  logic [OUT_W-1:0] sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      frac[a] = pt_q[a][F-1:0];
    end
  end

  // Table writes: permutation tables share one memory, one bank of 256 per axis
  assign perm_we    = in_acc & ((operation_i == OP_WR_PX) | (operation_i == OP_WR_PY) |
                                (operation_i == OP_WR_PZ));
  assign grad_we    = in_acc & (operation_i == OP_WR_GR);
  assign perm_waddr = {operation_i[1:0], entry_index_i};

  // Read order: x[cx], x[cx+1], y[cy], y[cy+1], z[cz], z[cz+1]
  always_comb begin
    case (cnt_q[2:1])
      2'd0:    cell_sel = pt_q[0][F+IDX_W-1:F];
      2'd1:    cell_sel = pt_q[1][F+IDX_W-1:F];
      default: cell_sel = pt_q[2][F+IDX_W-1:F];
    endcase
    perm_raddr = {cnt_q[2:1], cell_sel + IDX_W'(cnt_q[0])};
    hash = (cnt_q[2] ? perm_q[1] : perm_q[0]) ^ (cnt_q[1] ? perm_q[3] : perm_q[2])
         ^ (cnt_q[0] ? perm_q[5] : perm_q[4]);
  end

  gnt_ram #(.WIDTH(IDX_W), .DEPTH(3 * TABLE_SIZE)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr),
    .wdata_i (perm_value_i),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rdata)
  );

  gnt_ram #(.WIDTH(3 * GRAD_W), .DEPTH(TABLE_SIZE)) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (grad_we),
    .waddr_i (entry_index_i),
    .wdata_i ({grad_z_i, grad_y_i, grad_x_i}),
    .raddr_i (hash),
    .rdata_o (grad_rdata)
  );

  gnt_corner #(.FRAC_BITS(F)) u_corner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (tag1_q),
    .grad_i     (grad_rdata),
    .frac_x_i   (frac[0]),
    .frac_y_i   (frac[1]),
    .frac_z_i   (frac[2]),
    .sw_x_i     (s_q[0]),
    .sw_y_i     (s_q[1]),
    .sw_z_i     (s_q[2]),
    .busy_o     (pipe_busy),
    .term_vld_o (term_vld),
    .term_o     (term)
  );

  // Octave fold and final scaling
  always_comb begin
    oct_sat  = ({1'b0, octaves_i} > MAXO5) ? MAXO5 : {1'b0, octaves_i};
    noise_sh = noise_q >>> oct_n_q;
    mag      = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
    wide     = ({{OUT_FRAC{1'b0}}, mag} << SHL) >> SHR;
    sat      = (wide > MAGW'(OUT_MAX)) ? OUT_MAX : wide[OUT_W-1:0];
  end

  // Payload registers: point, perm words, smoothstep weights, accumulators, result
  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == OP_EVAL) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
    end else if (state_q == S_ACC) begin
      for (int a = 0; a < 3; a++) begin
        pt_q[a] <= {pt_q[a][30:0], 1'b0};
      end
    end
    for (int k = 0; k < 6; k++) begin
      if (rdv_q && rdk_q == 3'(k)) begin
        perm_q[k] <= perm_rdata;
      end
    end
    for (int a = 0; a < 3; a++) begin
      t_q[a] <= F'(({{F{1'b0}}, frac[a]} * {{F{1'b0}}, frac[a]}) >> F);
      s_q[a] <= (F+1)'(((2*F+2)'(t_q[a]) * (2*F+2)'(THREE_ONE - {1'b0, frac[a], 1'b0}))
                >> F);
    end
    if ((in_acc && operation_i == OP_EVAL) || state_q == S_ACC) begin
      noise_q <= '0;
    end else if (term_vld) begin
      noise_q <= noise_q + {{3{term[DW-1]}}, term};
    end
    if (in_acc && operation_i == OP_EVAL) begin
      sum_q <= '0;
    end else if (state_q == S_ACC) begin
      sum_q <= sum_q + {{2{noise_sh[NW-1]}}, noise_sh};
    end
    if (state_q == S_OUT && out_free) begin
      turb_q <= sat;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rdv_q       <= 1'b0;
      rdk_q       <= '0;
      oct_n_q     <= '0;
      oct_tot_q   <= '0;
      tag1_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rdv_q      <= (state_q == S_PERM) && (cnt_q < 3'd6);
      rdk_q      <= cnt_q;
      tag1_q.vld <= (state_q == S_CORNER);
      tag1_q.corner <= cnt_q;
      // Present a new result, or drop the one just taken
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && operation_i == OP_EVAL) begin
            oct_tot_q <= OCW'(oct_sat);
            oct_n_q   <= '0;
            cnt_q     <= '0;
            state_q   <= (oct_sat == 5'd0) ? S_OUT : S_PERM;
          end
        end
        S_PERM: begin
          if (cnt_q == 3'd6) begin
            cnt_q   <= '0;
            state_q <= S_CORNER;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_CORNER: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!pipe_busy && !tag1_q.vld && !term_vld) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          oct_n_q <= oct_n_q + OCW'(1);
          cnt_q   <= '0;
          state_q <= (oct_n_q + OCW'(1) == oct_tot_q) ? S_OUT : S_PERM;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign turbulence_o = turb_q;

  // Folding an octave must not race a corner still in flight
  a_acc_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC |-> !pipe_busy && !tag1_q.vld)
    else $error("octave folded with corners in flight");

  a_oct_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE && state_q != S_OUT |-> oct_n_q < oct_tot_q)
    else $error("octave counter beyond total");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_free |=> out_valid_o && state_q == S_IDLE)
    else $error("result not presented");

  a_corner_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CORNER && $past(state_q) == S_PERM |-> cnt_q == 3'd0)
    else $error("corner issue did not start at corner zero");

endmodule
`default_nettype wire
